// ----- rtl/bounded_deque_engine_defines.svh -----
// Assertion macros used by the deque engine controller.
`ifndef BOUNDED_DEQUE_ENGINE_DEFINES_SVH
`define BOUNDED_DEQUE_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BDE_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BDE_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/bde_pkg.sv -----
`timescale 1ns / 1ps
package bde_pkg;

	localparam logic [3:0] OP_PUSH_BACK  = 4'd0;
	localparam logic [3:0] OP_PUSH_FRONT = 4'd1;
	localparam logic [3:0] OP_POP_BACK   = 4'd2;
	localparam logic [3:0] OP_POP_FRONT  = 4'd3;
	localparam logic [3:0] OP_CLEAR      = 4'd4;
	localparam logic [3:0] OP_ROTATE     = 4'd5;
	localparam logic [3:0] OP_REVERSE    = 4'd6;
	localparam logic [3:0] OP_READ       = 4'd7;
	localparam logic [3:0] OP_WRITE      = 4'd8;
	localparam logic [3:0] OP_DELETE     = 4'd9;
	localparam logic [3:0] OP_INSERT     = 4'd10;
	localparam logic [3:0] OP_REMOVE     = 4'd11;
	localparam logic [3:0] OP_CONTAINS   = 4'd12;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_RANGE     = 3'd2;
	localparam logic [2:0] ST_AT_MAX    = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_OVERFLOW  = 3'd5;

	localparam logic [1:0] REG_BOUND  = 2'd0;
	localparam logic [1:0] REG_MAXLEN = 2'd1;

	typedef enum logic [4:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_STATUS,
		ACT_PUSH,
		ACT_CLEAR,
		ACT_RANGE,
		ACT_RD_A,
		ACT_RD_A1,
		ACT_RD_B_SAVE,
		ACT_RD_BM1,
		ACT_TAKE,
		ACT_WR_WORD,
		ACT_WR_A_RD_INC,
		ACT_WR_A_RD,
		ACT_WR_B_RD_DEC,
		ACT_WR_B_TMP,
		ACT_INC_A,
		ACT_DEC,
		ACT_INS_FIN,
		ACT_FOUND,
		ACT_DIV_INIT,
		ACT_DIV_STEP,
		ACT_DIV_FIX,
		ACT_EMIT
	} act_t;

	typedef enum logic [1:0] {
		SEL_IDX,
		SEL_ALL,
		SEL_LOW,
		SEL_HIGH
	} sel_t;

	typedef struct packed {
		act_t       act;
		sel_t       sel;
		logic [2:0] st;
	} cmd_t;

	typedef struct packed {
		logic [3:0] op;
		logic       empty;
		logic       lt2;
		logic       full;
		logic       bfull;
		logic       idx_ok;
		logic       match;
		logic       a_lt_b;
		logic       a_lt_cnt;
		logic       shift_del;
		logic       shift_ins;
		logic       div_last;
		logic       k_zero;
	} sts_t;

endpackage

// ----- rtl/bde_if.sv -----
`timescale 1ns / 1ps
interface bde_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  op;
	logic [31:0] data_word;
	logic [31:0] position;
	modport source(output valid, op, data_word, position, input ready);
	modport sink(input valid, op, data_word, position, output ready);
endinterface

interface bde_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_value;
	logic [2:0]  status;
	logic        found;
	logic [6:0]  length;
	modport source(output valid, read_value, status, found, length, input ready);
	modport sink(input valid, read_value, status, found, length, output ready);
endinterface

interface bde_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/bde_dp.sv -----
`timescale 1ns / 1ps
module bde_dp #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bde_pkg::cmd_t cmd,
	output bde_pkg::sts_t sts,
	input  logic [3:0]    in_op,
	input  logic [31:0]   in_word,
	input  logic [31:0]   in_pos,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_idx,
	input  logic [7:0]    cfg_data,
	output logic [31:0]   out_rv,
	output logic [2:0]    out_st,
	output logic          out_found,
	output logic [6:0]    out_len
);
	import bde_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int MW = (CW > 7) ? CW : 7;
	localparam int DW = DATA_WIDTH;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

	logic [DW-1:0] slots_q [DEPTH];

	logic [3:0]    op_q;
	logic [DW-1:0] word_q;
	logic [31:0]   pos_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] a_q, b_q, k_q, rem_q;
	logic [DW-1:0] tmp_q, rd_q, rv_q;
	logic [2:0]    st_q;
	logic          fd_q;
	logic [31:0]   dvd_q;
	logic [4:0]    dcnt_q;
	logic          bound_q;
	logic [6:0]    maxlen_q;

	logic [DW+31:0]   wext, rext;
	logic [CW+6:0]    lext;
	logic signed [32:0] pe, cnt_s;
	logic [CW-1:0]    clamp, idx_res;
	logic [CW:0]      dtry, dsub, cnt_x;
	logic [31:0]      pos_abs;
	logic [AW-1:0]    hm1, hp1;
	logic [CW-1:0]    ridx;
	logic             re, we;
	logic [AW-1:0]    waddr;
	logic [DW-1:0]    wdata;
	logic [MW-1:0]    cnt_m, max_m;

	function automatic logic [AW-1:0] phys(logic [AW-1:0] h, logic [CW-1:0] i);
		logic [CW:0] s;
		s = {{(CW+1-AW){1'b0}}, h} + {1'b0, i};
		if (s >= {1'b0, DEPTH_C}) begin
			s = s - {1'b0, DEPTH_C};
		end
		return s[AW-1:0];
	endfunction

	assign wext    = {{DW{1'b0}}, in_word};
	assign rext    = {32'd0, rv_q};
	assign lext    = {7'd0, count_q};
	assign cnt_s   = $signed({{(33-CW){1'b0}}, count_q});
	assign pe      = $signed({pos_q[31], pos_q}) + (pos_q[31] ? cnt_s : 33'sd0);
	assign pos_abs = pos_q[31] ? (~pos_q + 32'd1) : pos_q;
	assign cnt_x   = {1'b0, count_q};
	assign dtry    = {rem_q, dvd_q[31]};
	assign dsub    = dtry - cnt_x;
	assign hm1     = (head_q == '0) ? LAST_C : head_q - AW'(1);
	assign hp1     = (head_q == LAST_C) ? '0 : head_q + AW'(1);
	assign cnt_m   = MW'(count_q);
	assign max_m   = MW'(maxlen_q);

	always_comb begin
		if (pe[32]) begin
			clamp = '0;
		end else if (pe > cnt_s) begin
			clamp = count_q;
		end else begin
			clamp = pe[CW-1:0];
		end
		unique case (op_q)
			OP_POP_BACK: idx_res = count_q - CW'(1);
			OP_READ, OP_WRITE, OP_DELETE: idx_res = pe[CW-1:0];
			OP_INSERT: idx_res = clamp;
			default: idx_res = '0;
		endcase
	end

	always_comb begin
		sts.op        = op_q;
		sts.empty     = (count_q == '0);
		sts.lt2       = (count_q < CW'(2));
		sts.full      = (count_q >= DEPTH_C);
		sts.bfull     = bound_q && (cnt_m >= max_m);
		sts.idx_ok    = !pe[32] && (pe < cnt_s);
		sts.match     = (rd_q == word_q);
		sts.a_lt_b    = (a_q < b_q);
		sts.a_lt_cnt  = (a_q < count_q);
		sts.shift_del = (({1'b0, a_q} + {{CW{1'b0}}, 1'b1}) < cnt_x);
		sts.shift_ins = (b_q > a_q);
		sts.div_last  = (dcnt_q == 5'd31);
		sts.k_zero    = (k_q == '0);
	end

	always_comb begin
		re   = 1'b1;
		ridx = a_q;
		unique case (cmd.act)
			ACT_RD_A: ridx = a_q;
			ACT_RD_A1: ridx = a_q + CW'(1);
			ACT_RD_B_SAVE: ridx = b_q;
			ACT_RD_BM1: ridx = b_q - CW'(1);
			default: re = 1'b0;
		endcase
	end

	always_comb begin
		we    = 1'b1;
		waddr = phys(head_q, a_q);
		wdata = word_q;
		unique case (cmd.act)
			ACT_PUSH: waddr = (op_q == OP_PUSH_BACK) ? phys(head_q, count_q) : hm1;
			ACT_WR_WORD, ACT_INS_FIN: wdata = word_q;
			ACT_WR_A_RD_INC, ACT_WR_A_RD: wdata = rd_q;
			ACT_WR_B_RD_DEC: begin
				waddr = phys(head_q, b_q);
				wdata = rd_q;
			end
			ACT_WR_B_TMP: begin
				waddr = phys(head_q, b_q);
				wdata = tmp_q;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			slots_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= slots_q[phys(head_q, ridx)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			bound_q  <= 1'b0;
			maxlen_q <= 7'd64;
		end else begin
			if (cfg_we && cfg_idx == REG_BOUND) begin
				bound_q <= cfg_data[0];
			end
			if (cfg_we && cfg_idx == REG_MAXLEN) begin
				maxlen_q <= cfg_data[6:0];
			end
			unique case (cmd.act)
				ACT_PUSH: begin
					if (op_q == OP_PUSH_BACK) begin
						if (sts.bfull) begin
							head_q <= hp1;
						end else begin
							count_q <= count_q + CW'(1);
						end
					end else begin
						head_q <= hm1;
						if (!sts.bfull) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				ACT_CLEAR: begin
					head_q  <= '0;
					count_q <= '0;
				end
				ACT_TAKE: begin
					if (op_q == OP_POP_BACK) begin
						count_q <= count_q - CW'(1);
					end else if (op_q == OP_POP_FRONT) begin
						head_q  <= hp1;
						count_q <= count_q - CW'(1);
					end
				end
				ACT_DEC: count_q <= count_q - CW'(1);
				ACT_INS_FIN: count_q <= count_q + CW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.act)
			ACT_LOAD: begin
				op_q   <= in_op;
				word_q <= wext[DW-1:0];
				pos_q  <= in_pos;
				rv_q   <= '0;
				st_q   <= ST_OK;
				fd_q   <= 1'b0;
			end
			ACT_STATUS: st_q <= cmd.st;
			ACT_RANGE: begin
				unique case (cmd.sel)
					SEL_IDX: begin
						a_q <= idx_res;
						b_q <= count_q;
					end
					SEL_ALL: begin
						a_q <= '0;
						b_q <= count_q - CW'(1);
					end
					SEL_LOW: begin
						a_q <= '0;
						b_q <= k_q - CW'(1);
					end
					SEL_HIGH: begin
						a_q <= k_q;
						b_q <= count_q - CW'(1);
					end
				endcase
			end
			ACT_TAKE: rv_q <= rd_q;
			ACT_RD_B_SAVE: tmp_q <= rd_q;
			ACT_WR_A_RD_INC, ACT_INC_A: a_q <= a_q + CW'(1);
			ACT_WR_B_RD_DEC: b_q <= b_q - CW'(1);
			ACT_WR_B_TMP: begin
				a_q <= a_q + CW'(1);
				b_q <= b_q - CW'(1);
			end
			ACT_FOUND: fd_q <= 1'b1;
			ACT_DIV_INIT: begin
				dvd_q  <= pos_abs;
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			ACT_DIV_STEP: begin
				rem_q  <= (dtry >= cnt_x) ? dsub[CW-1:0] : dtry[CW-1:0];
				dvd_q  <= {dvd_q[30:0], 1'b0};
				dcnt_q <= dcnt_q + 5'd1;
			end
			ACT_DIV_FIX: k_q <= (pos_q[31] && rem_q != '0) ? count_q - rem_q : rem_q;
			ACT_EMIT: begin
				out_rv    <= rext[31:0];
				out_st    <= st_q;
				out_found <= fd_q;
				out_len   <= lext[6:0];
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/bde_ctrl.sv -----
`timescale 1ns / 1ps
`include "bounded_deque_engine_defines.svh"
module bde_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output bde_pkg::cmd_t cmd,
	input  bde_pkg::sts_t sts
);
	import bde_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_EXEC, S_RD1, S_GET1, S_WR1,
		S_DEL_CHK, S_DEL_WR, S_SRCH_CHK, S_SRCH_CMP,
		S_INS_CHK, S_INS_WR, S_REV_CHK, S_REV_RDB, S_REV_WRA, S_REV_WRB,
		S_DIV, S_FIX, S_ROT0, S_DONE
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] phase_q, phase_d;
	logic       out_valid_q;
	logic       emit;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		emit    = 1'b0;
		cmd     = '{act: ACT_NONE, sel: SEL_IDX, st: ST_OK};
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.act = ACT_LOAD;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
				unique case (sts.op)
					OP_PUSH_BACK, OP_PUSH_FRONT: begin
						if (sts.bfull && sts.empty) begin
							cmd.act = ACT_NONE;
						end else if (!sts.bfull && sts.full) begin
							cmd.act = ACT_STATUS;
							cmd.st  = ST_OVERFLOW;
						end else begin
							cmd.act = ACT_PUSH;
						end
					end
					OP_POP_BACK, OP_POP_FRONT: begin
						if (sts.empty) begin
							cmd.act = ACT_STATUS;
							cmd.st  = ST_EMPTY;
						end else begin
							cmd.act = ACT_RANGE;
							state_d = S_RD1;
						end
					end
					OP_CLEAR: cmd.act = ACT_CLEAR;
					OP_ROTATE: begin
						if (!sts.lt2) begin
							cmd.act = ACT_DIV_INIT;
							state_d = S_DIV;
						end
					end
					OP_REVERSE: begin
						if (!sts.lt2) begin
							cmd.act = ACT_RANGE;
							cmd.sel = SEL_ALL;
							phase_d = 2'd2;
							state_d = S_REV_CHK;
						end
					end
					OP_READ, OP_WRITE, OP_DELETE: begin
						if (!sts.idx_ok) begin
							cmd.act = ACT_STATUS;
							cmd.st  = ST_RANGE;
						end else begin
							cmd.act = ACT_RANGE;
							priority case (sts.op)
								OP_READ: state_d = S_RD1;
								OP_WRITE: state_d = S_WR1;
								default: state_d = S_DEL_CHK;
							endcase
						end
					end
					OP_INSERT: begin
						if (sts.bfull) begin
							cmd.act = ACT_STATUS;
							cmd.st  = ST_AT_MAX;
						end else if (sts.full) begin
							cmd.act = ACT_STATUS;
							cmd.st  = ST_OVERFLOW;
						end else begin
							cmd.act = ACT_RANGE;
							state_d = S_INS_CHK;
						end
					end
					OP_REMOVE, OP_CONTAINS: begin
						cmd.act = ACT_RANGE;
						state_d = S_SRCH_CHK;
					end
					default: ;
				endcase
			end
			S_RD1: begin
				cmd.act = ACT_RD_A;
				state_d = S_GET1;
			end
			S_GET1: begin
				cmd.act = ACT_TAKE;
				state_d = S_DONE;
			end
			S_WR1: begin
				cmd.act = ACT_WR_WORD;
				state_d = S_DONE;
			end
			S_DEL_CHK: begin
				if (sts.shift_del) begin
					cmd.act = ACT_RD_A1;
					state_d = S_DEL_WR;
				end else begin
					cmd.act = ACT_DEC;
					state_d = S_DONE;
				end
			end
			S_DEL_WR: begin
				cmd.act = ACT_WR_A_RD_INC;
				state_d = S_DEL_CHK;
			end
			S_SRCH_CHK: begin
				if (sts.a_lt_cnt) begin
					cmd.act = ACT_RD_A;
					state_d = S_SRCH_CMP;
				end else begin
					if (sts.op == OP_REMOVE) begin
						cmd.act = ACT_STATUS;
						cmd.st  = ST_NOT_FOUND;
					end
					state_d = S_DONE;
				end
			end
			S_SRCH_CMP: begin
				if (!sts.match) begin
					cmd.act = ACT_INC_A;
					state_d = S_SRCH_CHK;
				end else if (sts.op == OP_REMOVE) begin
					state_d = S_DEL_CHK;
				end else begin
					cmd.act = ACT_FOUND;
					state_d = S_DONE;
				end
			end
			S_INS_CHK: begin
				if (sts.shift_ins) begin
					cmd.act = ACT_RD_BM1;
					state_d = S_INS_WR;
				end else begin
					cmd.act = ACT_INS_FIN;
					state_d = S_DONE;
				end
			end
			S_INS_WR: begin
				cmd.act = ACT_WR_B_RD_DEC;
				state_d = S_INS_CHK;
			end
			S_REV_CHK: begin
				if (sts.a_lt_b) begin
					cmd.act = ACT_RD_A;
					state_d = S_REV_RDB;
				end else if (phase_q == 2'd0) begin
					cmd.act = ACT_RANGE;
					cmd.sel = SEL_LOW;
					phase_d = 2'd1;
				end else if (phase_q == 2'd1) begin
					cmd.act = ACT_RANGE;
					cmd.sel = SEL_HIGH;
					phase_d = 2'd2;
				end else begin
					state_d = S_DONE;
				end
			end
			S_REV_RDB: begin
				cmd.act = ACT_RD_B_SAVE;
				state_d = S_REV_WRA;
			end
			S_REV_WRA: begin
				cmd.act = ACT_WR_A_RD;
				state_d = S_REV_WRB;
			end
			S_REV_WRB: begin
				cmd.act = ACT_WR_B_TMP;
				state_d = S_REV_CHK;
			end
			S_DIV: begin
				cmd.act = ACT_DIV_STEP;
				if (sts.div_last) begin
					state_d = S_FIX;
				end
			end
			S_FIX: begin
				cmd.act = ACT_DIV_FIX;
				state_d = S_ROT0;
			end
			S_ROT0: begin
				if (sts.k_zero) begin
					state_d = S_DONE;
				end else begin
					cmd.act = ACT_RANGE;
					cmd.sel = SEL_ALL;
					phase_d = 2'd0;
					state_d = S_REV_CHK;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.act = ACT_EMIT;
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= 2'd2;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`BDE_ASSERT_NXT(a_div_exit, (state_q == S_DIV && sts.div_last), (state_q == S_FIX), "divide did not finish")
	`BDE_ASSERT_NXT(a_done_hold, (state_q == S_DONE && out_valid_q && !out_ready), (state_q == S_DONE && out_valid_q), "result lost under stall")
	`BDE_ASSERT_NXT(a_srch_end, (state_q == S_SRCH_CHK && !sts.a_lt_cnt), (state_q == S_DONE), "search ran past length")

endmodule

// ----- rtl/bounded_deque_engine.sv -----
`timescale 1ns / 1ps
// Bounded double-ended queue of words held in a ring of DEPTH slots.
// req carries one item per op (op, data_word, position); rsp returns one item
// per req item (read_value, status, found, length). cfg writes bound_enable
// (index 0) and max_length (index 1); cfg is always ready. cfg must be
// written only while no op is in flight; the block does not enforce this.
// The sequencer takes one step a cycle, but holds a finished result while
// rsp stalls. Delete and insert shift one moved entry at a time; remove and
// contains search entry by entry, and remove then deletes the match; reverse
// swaps pairs; rotate runs a 32-step remainder unit and then three
// reversals, or none when the amount reduces to zero.
// One item is in flight at a time; req is taken again the cycle after the
// result enters the rsp register.
// Each step is bounded by the single read and single write port of the slots.
// Reset clears head, length and the registers (bound off, max_length 64);
// slot contents are left as they are. When rsp stalls, the result holds in
// the rsp register and the next item may still be accepted and worked.
module bounded_deque_engine #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	bde_req_if.sink   req,
	bde_rsp_if.source rsp,
	bde_cfg_if.sink   cfg
);
	import bde_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	bde_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	bde_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_op     (req.op),
		.in_word   (req.data_word),
		.in_pos    (req.position),
		.cfg_we    (cfg.valid),
		.cfg_idx   (cfg.index),
		.cfg_data  (cfg.data),
		.out_rv    (rsp.read_value),
		.out_st    (rsp.status),
		.out_found (rsp.found),
		.out_len   (rsp.length)
	);

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import bde_pkg::*;

	localparam int          DEPTH     = 64;
	localparam longint      CYCLE_CAP = 3000000;

	typedef struct {
		logic [31:0] read_value;
		logic [2:0]  status;
		logic        found;
		logic [6:0]  length;
	} deque_result_t;

	logic clk;
	logic arst_n;

	bde_req_if req ();
	bde_rsp_if rsp ();
	bde_cfg_if cfg ();

	bounded_deque_engine #(.DEPTH(DEPTH), .DATA_WIDTH(32)) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cfg   (cfg)
	);

	logic [31:0]   words[$];
	logic          bound_on;
	logic [6:0]    len_cap;
	deque_result_t pending[$];
	int            fail_count;
	longint        cycle_count;
	int            burst_left;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic deque_result_t apply_op(logic [3:0] op, logic [31:0] w,
			logic [31:0] pos_raw);
		deque_result_t r;
		longint        p;
		longint        m;
		longint        at;
		int            k;
		logic [31:0]   tmp[$];
		r.read_value = '0;
		r.status     = ST_OK;
		r.found      = 1'b0;
		p = longint'($signed(pos_raw));
		case (op)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (bound_on && words.size() >= len_cap) begin
					if (words.size() != 0) begin
						if (op == OP_PUSH_BACK) begin
							void'(words.pop_front());
							words.push_back(w);
						end else begin
							void'(words.pop_back());
							words.push_front(w);
						end
					end
				end else if (words.size() >= DEPTH) begin
					r.status = ST_OVERFLOW;
				end else if (op == OP_PUSH_BACK) begin
					words.push_back(w);
				end else begin
					words.push_front(w);
				end
			end
			OP_POP_BACK: begin
				if (words.size() == 0) r.status = ST_EMPTY;
				else r.read_value = words.pop_back();
			end
			OP_POP_FRONT: begin
				if (words.size() == 0) r.status = ST_EMPTY;
				else r.read_value = words.pop_front();
			end
			OP_CLEAR: words.delete();
			OP_ROTATE: begin
				if (words.size() > 1) begin
					m = words.size();
					k = int'(((p % m) + m) % m);
					tmp = words;
					for (int i = 0; i < m; i++) words[(i + k) % m] = tmp[i];
				end
			end
			OP_REVERSE: begin
				tmp = words;
				foreach (tmp[i]) words[i] = tmp[tmp.size() - 1 - i];
			end
			OP_READ, OP_WRITE, OP_DELETE: begin
				if (p < 0) p += words.size();
				if (p < 0 || p >= words.size()) begin
					r.status = ST_RANGE;
				end else if (op == OP_READ) begin
					r.read_value = words[p];
				end else if (op == OP_WRITE) begin
					words[p] = w;
				end else begin
					words.delete(p);
				end
			end
			OP_INSERT: begin
				if (bound_on && words.size() >= len_cap) begin
					r.status = ST_AT_MAX;
				end else if (words.size() >= DEPTH) begin
					r.status = ST_OVERFLOW;
				end else begin
					at = p;
					if (at < 0) at += words.size();
					if (at < 0) at = 0;
					if (at > words.size()) at = words.size();
					words.insert(at, w);
				end
			end
			OP_REMOVE: begin
				r.status = ST_NOT_FOUND;
				foreach (words[i]) begin
					if (r.status == ST_NOT_FOUND && words[i] == w) begin
						words.delete(i);
						r.status = ST_OK;
						break;
					end
				end
			end
			OP_CONTAINS: begin
				foreach (words[i]) if (words[i] == w) r.found = 1'b1;
			end
			default: ;
		endcase
		r.length = 7'(words.size());
		return r;
	endfunction

	always @(posedge clk) begin
		deque_result_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending.size() == 0) begin
				$error("result with no item pending");
				fail_count++;
			end else begin
				e = pending.pop_front();
				if (rsp.read_value !== e.read_value) begin
					$error("read_value: expected %h, got %h", e.read_value, rsp.read_value);
					fail_count++;
				end
				if (rsp.status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, rsp.status);
					fail_count++;
				end
				if (rsp.found !== e.found) begin
					$error("found: expected %0d, got %0d", e.found, rsp.found);
					fail_count++;
				end
				if (rsp.length !== e.length) begin
					$error("length: expected %0d, got %0d", e.length, rsp.length);
					fail_count++;
				end
			end
		end
	end

	// receiver stall pattern
	initial begin
		int mode;
		int span;
		rsp.ready <= 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(5, 60);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					0: rsp.ready <= 1'b1;
					1: rsp.ready <= ($urandom_range(0, 1) == 1);
					2: rsp.ready <= ($urandom_range(0, 7) == 0);
					default: rsp.ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	task automatic send_op(logic [3:0] op, logic [31:0] w, logic [31:0] pos);
		req.valid     <= 1'b1;
		req.op        <= op;
		req.data_word <= w;
		req.position  <= pos;
		do @(posedge clk); while (!req.ready);
		pending.push_back(apply_op(op, w, pos));
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if ($urandom_range(0, 3) != 0) begin
				req.valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		burst_left = $urandom_range(1, 16);
		do @(posedge clk); while (pending.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		drain();
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		if (idx == REG_BOUND) bound_on = val[0];
		else if (idx == REG_MAXLEN) len_cap = val[6:0];
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_pos();
		if ($urandom_range(0, 9) == 0) return $urandom;
		return 32'($signed($urandom_range(0, 140)) - 70);
	endfunction

	function automatic logic [31:0] pick_word();
		if ($urandom_range(0, 2) == 0) return $urandom;
		return 32'($urandom_range(0, 15));
	endfunction

	task automatic test_ends();
		send_op(OP_POP_BACK, 32'h0, 32'h0);
		send_op(OP_POP_FRONT, 32'h0, 32'h0);
		send_op(OP_PUSH_BACK, 32'hFFFF_FFFF, 32'h0);
		send_op(OP_PUSH_FRONT, 32'h0000_0000, 32'h0);
		send_op(OP_PUSH_BACK, 32'h8000_0001, 32'h0);
		send_op(OP_POP_FRONT, 32'h0, 32'h0);
		send_op(OP_POP_BACK, 32'h0, 32'h0);
	endtask

	task automatic test_index_ops();
		send_op(OP_READ, 32'h0, 32'hFFFF_FFFF);
		send_op(OP_READ, 32'h0, 32'h8000_0000);
		send_op(OP_WRITE, 32'h1234_5678, 32'h7FFF_FFFF);
		send_op(OP_INSERT, 32'hA5A5_A5A5, 32'h8000_0000);
		send_op(OP_INSERT, 32'h5A5A_5A5A, 32'h7FFF_FFFF);
		send_op(OP_WRITE, 32'h0000_0007, 32'hFFFF_FFFE);
		send_op(OP_DELETE, 32'h0, 32'h0000_0005);
		send_op(OP_DELETE, 32'h0, 32'hFFFF_FFFF);
	endtask

	task automatic test_shape_ops();
		send_op(OP_ROTATE, 32'h0, 32'h0000_0003);
		send_op(OP_ROTATE, 32'h0, 32'h8000_0000);
		send_op(OP_REVERSE, 32'h0, 32'h0);
		send_op(OP_CONTAINS, 32'h0000_0007, 32'h0);
		send_op(OP_CONTAINS, 32'hDEAD_BEEF, 32'h0);
		send_op(OP_REMOVE, 32'hDEAD_BEEF, 32'h0);
		send_op(OP_REMOVE, 32'h0000_0007, 32'h0);
		send_op(4'd13, 32'h0, 32'h0);
		send_op(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(OP_CLEAR, 32'h0, 32'h0);
	endtask

	task automatic test_random(int count, int push_pct);
		logic [3:0] op;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < push_pct) op = $urandom_range(0, 1) ? OP_PUSH_BACK
					: OP_PUSH_FRONT;
			else if ($urandom_range(0, 60) == 0) op = OP_CLEAR;
			else op = 4'($urandom_range(0, 15));
			send_op(op, pick_word(), pick_pos());
		end
	endtask

	initial begin
		arst_n     <= 1'b0;
		req.valid  <= 1'b0;
		req.op     <= '0;
		req.data_word <= '0;
		req.position  <= '0;
		cfg.valid  <= 1'b0;
		cfg.index  <= '0;
		cfg.data   <= '0;
		bound_on    = 1'b0;
		len_cap     = 7'd64;
		fail_count  = 0;
		cycle_count = 0;
		burst_left  = 4;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ends();
		test_index_ops();
		test_shape_ops();
		test_random(250, 60);
		test_random(100, 90);
		write_reg(REG_MAXLEN, 8'd5);
		write_reg(REG_BOUND, 8'd1);
		test_random(150, 50);
		write_reg(REG_MAXLEN, 8'd0);
		test_random(60, 50);
		write_reg(REG_MAXLEN, 8'd64);
		test_random(250, 70);
		write_reg(REG_MAXLEN, 8'd20);
		test_random(150, 40);
		write_reg(REG_BOUND, 8'd0);
		test_random(170, 45);
		drain();

		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/bde_pkg.sv
rtl/bde_if.sv
rtl/bde_dp.sv
rtl/bde_ctrl.sv
rtl/bounded_deque_engine.sv
tb/tb_top.sv
